// ----- rtl/core/text_to_hid_key_combo_encoder_assert.svh -----
// assertion macros for the text to hid key combo encoder
// no dependencies; included by modules that carry checks
`ifndef TEXT_TO_HID_KEY_COMBO_ENCODER_ASSERT_SVH
`define TEXT_TO_HID_KEY_COMBO_ENCODER_ASSERT_SVH
`ifndef SYNTH
`define TTHK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define TTHK_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TTHK_ASSERT(lbl, clk, rst, prop, msg)
`define TTHK_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/core/tthk_pkg.sv -----
// shared types, key name table and character mapping
// no dependencies
`default_nettype none
package tthk_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] modifier_bits;
    logic [7:0] key_code;
    logic [1:0] error_code;
    logic       last_of_line;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] mods;
    logic [7:0] code;
  } map_t;

  typedef logic [87:0] name_t;

  localparam logic       KIND_COMBO  = 1'b0;
  localparam logic       KIND_ERROR  = 1'b1;
  localparam logic [1:0] ERR_UNKNOWN = 2'd0;
  localparam logic [1:0] ERR_MULTI   = 2'd1;
  localparam logic [1:0] ERR_LEN     = 2'd2;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] MOD_CTRL  = 8'h01;
  localparam logic [7:0] MOD_SHIFT = 8'h02;
  localparam logic [7:0] MOD_ALT   = 8'h04;
  localparam logic [7:0] MOD_GUI   = 8'h08;

  localparam logic [7:0] KEY_COMMA = 8'h36;
  localparam logic [7:0] KEY_BSL   = 8'h31;

  localparam int QUEUE_DEPTH = 4;
  localparam int NKEY = 40;

  localparam name_t KEY_NAME [NKEY] = '{
    "ctrl", "control", "alt", "shift", "super", "win", "gui", "cmd",
    "enter", "return", "tab", "esc", "escape", "backspace", "delete", "del",
    "space", "up", "down", "left", "right", "home", "end", "pageup",
    "pagedown", "insert", "capslock", "printscreen",
    "f1", "f2", "f3", "f4", "f5", "f6", "f7", "f8", "f9", "f10", "f11", "f12"
  };

  localparam logic [3:0] KEY_LEN [NKEY] = '{
    4'd4, 4'd7, 4'd3, 4'd5, 4'd5, 4'd3, 4'd3, 4'd3,
    4'd5, 4'd6, 4'd3, 4'd3, 4'd6, 4'd9, 4'd6, 4'd3,
    4'd5, 4'd2, 4'd4, 4'd4, 4'd5, 4'd4, 4'd3, 4'd6,
    4'd8, 4'd6, 4'd8, 4'd11,
    4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3
  };

  localparam logic [7:0] KEY_CODE [NKEY] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h28, 8'h28, 8'h2B, 8'h29, 8'h29, 8'h2A, 8'h4C, 8'h4C,
    8'h2C, 8'h52, 8'h51, 8'h50, 8'h4F, 8'h4A, 8'h4D, 8'h4B,
    8'h4E, 8'h49, 8'h39, 8'h46,
    8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45
  };

  localparam logic [7:0] KEY_MODS [NKEY] = '{
    MOD_CTRL, MOD_CTRL, MOD_ALT, MOD_SHIFT, MOD_GUI, MOD_GUI, MOD_GUI, MOD_GUI,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // character j of key name k, zero past its end
  function automatic logic [7:0] key_char(int k, logic [3:0] j);
    name_t s;
    int    sh;
    s  = KEY_NAME[k];
    sh = (int'(KEY_LEN[k]) - 1 - int'(j)) * 8;
    if (j >= KEY_LEN[k]) key_char = 8'h00;
    else key_char = 8'(s >> sh);
  endfunction

  function automatic logic [7:0] fold(logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) fold = c + 8'd32;
    else fold = c;
  endfunction

  function automatic map_t map_char(logic [7:0] c);
    map_t m;
    m = '{ok: 1'b1, mods: 8'h00, code: 8'h00};
    if (c >= 8'h61 && c <= 8'h7A) m.code = c - 8'h5D;
    else if (c >= 8'h41 && c <= 8'h5A) begin
      m.code = c - 8'h3D;
      m.mods = MOD_SHIFT;
    end else if (c == 8'h30) m.code = 8'h27;
    else if (c >= 8'h31 && c <= 8'h39) m.code = c - 8'h13;
    else begin
      case (c)
        8'h20: m.code = 8'h2C;
        8'h2E: m.code = 8'h37;
        8'h2C: m.code = 8'h36;
        8'h2D: m.code = 8'h2D;
        8'h3D: m.code = 8'h2E;
        8'h2F: m.code = 8'h38;
        8'h3B: m.code = 8'h33;
        8'h27: m.code = 8'h34;
        8'h5B: m.code = 8'h2F;
        8'h5D: m.code = 8'h30;
        8'h5C: m.code = KEY_BSL;
        8'h60: m.code = 8'h35;
        8'h09: m.code = 8'h2B;
        8'h0A: m.code = 8'h28;
        8'h3C: begin
          m.code = KEY_COMMA;
          m.mods = MOD_SHIFT;
        end
        default: m.ok = 1'b0;
      endcase
    end
    return m;
  endfunction

  function automatic result_t mk_combo(logic [7:0] mods, logic [7:0] code);
    return '{result_kind: KIND_COMBO, modifier_bits: mods, key_code: code,
             error_code: ERR_UNKNOWN, last_of_line: 1'b0};
  endfunction

  function automatic result_t mk_error(logic [1:0] err);
    return '{result_kind: KIND_ERROR, modifier_bits: 8'h00, key_code: 8'h00,
             error_code: err, last_of_line: 1'b0};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/tthk_walk.sv -----
// line store and walker: loads characters, then parses the line into key combo and error results
// depends on tthk_pkg
`default_nettype none
module tthk_walk import tthk_pkg::*; #(
  parameter int LINE_CHARS = 64,
  parameter int TAG_CHARS  = 64
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_item,
  input  wire logic     q_full,
  output logic          q_wr,
  output result_t       q_data
);

  localparam int AW = $clog2(LINE_CHARS);
  localparam int PW = AW + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_CHAR, S_BSL, S_SCAN, S_TAG, S_FLUSH
  } state_t;

  state_t          state, state_next;
  logic [AW-1:0]   len, len_next, zn, zn_next;
  logic            zs, zs_next;
  logic [PW-1:0]   n, n_next, p, p_next, q, q_next, ptr, ptr_next;
  logic [7:0]      mem [LINE_CHARS];
  logic [7:0]      rdata;
  logic            in_piece, in_piece_next, sp_pend, sp_pend_next;
  logic            broken, broken_next, have_key, have_key_next;
  logic [3:0]      cnt, cnt_next;
  logic [7:0]      first, first_next, all_mods, all_mods_next, key, key_next;
  logic [NKEY-1:0] match, match_next, step_ok, hit;
  result_t         pend, pend_next;
  logic            have_pend, have_pend_next;

  logic            acc, wr_en;
  logic [PW-1:0]   nval, tlen;
  logic            bad_len;
  map_t            mc, mf;
  logic [7:0]      fc, tbl_code, tbl_mods, pk_code, pk_mods, end_mods, end_key;
  logic            pk_ok, mod_only, fault;
  logic            emit_v, stall, adv_v;
  result_t         emit_r;
  logic [PW-1:0]   adv_to;

  assign full  = (state != S_IDLE);
  assign acc   = push && !full;
  assign wr_en = acc && (len < AW'(LINE_CHARS - 1));

  always_comb begin
    if (zs) nval = PW'(zn);
    else if (wr_en && in_item.char_code == 8'h00) nval = PW'(len);
    else if (wr_en) nval = PW'(len) + 1'b1;
    else nval = PW'(len);
  end

  assign mc      = map_char(rdata);
  assign mf      = map_char(first);
  assign fc      = fold(rdata);
  assign tlen    = ptr - p - 1'b1;
  assign bad_len = (tlen == '0) ||
                   ({{(32 - PW){1'b0}}, tlen} >= 32'(TAG_CHARS));

  // piece matching against the name table
  always_comb begin
    tbl_code = 8'h00;
    tbl_mods = 8'h00;
    for (int k = 0; k < NKEY; k++) begin
      step_ok[k] = (cnt < KEY_LEN[k]) && (key_char(k, cnt) == fc);
      hit[k]     = match[k] && (KEY_LEN[k] == cnt) && !broken;
      if (hit[k]) begin
        tbl_code = tbl_code | KEY_CODE[k];
        tbl_mods = tbl_mods | KEY_MODS[k];
      end
    end
  end

  always_comb begin
    if (|hit) begin
      pk_ok   = 1'b1;
      pk_code = tbl_code;
      pk_mods = tbl_mods;
    end else begin
      pk_ok   = (cnt == 4'd1) && !broken && mf.ok;
      pk_code = mf.code;
      pk_mods = mf.mods;
    end
  end

  assign mod_only = (pk_code == 8'h00) && (pk_mods != 8'h00);
  assign fault    = !pk_ok || (!mod_only && have_key);
  assign end_mods = all_mods | (in_piece ? pk_mods : 8'h00);
  assign end_key  = (in_piece && !mod_only) ? pk_code : key;

  // result produced in this cycle
  always_comb begin
    emit_v = 1'b0;
    emit_r = mk_combo(8'h00, 8'h00);
    unique case (state)
      S_CHAR: begin
        if (!(rdata == CH_BSL && (p + 1'b1) < n) && rdata != CH_LT) begin
          emit_v = mc.ok;
          emit_r = mk_combo(mc.mods, mc.code);
        end
      end
      S_BSL: begin
        emit_v = 1'b1;
        emit_r = (rdata == CH_LT) ? mk_combo(MOD_SHIFT, KEY_COMMA)
                                  : mk_combo(8'h00, KEY_BSL);
      end
      S_SCAN: begin
        if (ptr >= n) begin
          emit_v = 1'b1;
          emit_r = mk_combo(MOD_SHIFT, KEY_COMMA);
        end else if (rdata == CH_GT && bad_len) begin
          emit_v = 1'b1;
          emit_r = mk_error(ERR_LEN);
        end
      end
      S_TAG: begin
        if (ptr == q) begin
          emit_v = 1'b1;
          if (in_piece && fault) emit_r = mk_error(pk_ok ? ERR_MULTI : ERR_UNKNOWN);
          else emit_r = mk_combo(end_mods, end_key);
        end else if (rdata == CH_PLUS && in_piece && fault) begin
          emit_v = 1'b1;
          emit_r = mk_error(pk_ok ? ERR_MULTI : ERR_UNKNOWN);
        end
      end
      default: ;
    endcase
  end

  assign stall = have_pend && q_full && (emit_v || state == S_FLUSH);
  assign q_wr  = have_pend && !q_full && (emit_v || state == S_FLUSH);
  always_comb begin
    q_data = pend;
    q_data.last_of_line = (state == S_FLUSH);
  end

  always_comb begin
    state_next    = state;
    len_next      = len;
    zs_next       = zs;
    zn_next       = zn;
    n_next        = n;
    p_next        = p;
    q_next        = q;
    ptr_next      = ptr;
    in_piece_next = in_piece;
    sp_pend_next  = sp_pend;
    broken_next   = broken;
    have_key_next = have_key;
    cnt_next      = cnt;
    first_next    = first;
    all_mods_next = all_mods;
    key_next      = key;
    match_next    = match;
    pend_next     = pend;
    have_pend_next = have_pend;
    adv_v         = 1'b0;
    adv_to        = p;
    if (!stall) begin
      if (emit_v) begin
        pend_next      = emit_r;
        have_pend_next = 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            if (wr_en) len_next = len + 1'b1;
            if (wr_en && in_item.char_code == 8'h00 && !zs) begin
              zs_next = 1'b1;
              zn_next = len;
            end
            if (in_item.end_of_line) begin
              len_next   = '0;
              zs_next    = 1'b0;
              n_next     = nval;
              p_next     = '0;
              ptr_next   = '0;
              state_next = (nval == '0) ? S_IDLE : S_CHAR;
            end
          end
        end
        S_CHAR: begin
          if (rdata == CH_BSL && (p + 1'b1) < n) begin
            ptr_next   = p + 1'b1;
            state_next = S_BSL;
          end else if (rdata == CH_LT) begin
            ptr_next   = p + 1'b1;
            state_next = S_SCAN;
          end else begin
            adv_v  = 1'b1;
            adv_to = p + 1'b1;
          end
        end
        S_BSL: begin
          adv_v  = 1'b1;
          adv_to = (rdata == CH_LT) ? p + PW'(2) : p + 1'b1;
        end
        S_SCAN: begin
          if (ptr >= n) begin
            adv_v  = 1'b1;
            adv_to = p + 1'b1;
          end else if (rdata == CH_GT) begin
            if (bad_len) begin
              adv_v  = 1'b1;
              adv_to = ptr + 1'b1;
            end else begin
              q_next        = ptr;
              ptr_next      = p + 1'b1;
              in_piece_next = 1'b0;
              sp_pend_next  = 1'b0;
              broken_next   = 1'b0;
              have_key_next = 1'b0;
              cnt_next      = '0;
              all_mods_next = 8'h00;
              key_next      = 8'h00;
              match_next    = '1;
              state_next    = S_TAG;
            end
          end else begin
            ptr_next = ptr + 1'b1;
          end
        end
        S_TAG: begin
          if (ptr == q) begin
            adv_v  = 1'b1;
            adv_to = q + 1'b1;
          end else if (rdata == CH_PLUS) begin
            if (in_piece && fault) begin
              adv_v  = 1'b1;
              adv_to = q + 1'b1;
            end else begin
              if (in_piece) begin
                all_mods_next = all_mods | pk_mods;
                if (!mod_only) begin
                  key_next      = pk_code;
                  have_key_next = 1'b1;
                end
              end
              in_piece_next = 1'b0;
              sp_pend_next  = 1'b0;
              broken_next   = 1'b0;
              cnt_next      = '0;
              match_next    = '1;
              ptr_next      = ptr + 1'b1;
            end
          end else begin
            in_piece_next = 1'b1;
            ptr_next      = ptr + 1'b1;
            if (rdata == CH_SPACE) begin
              if (cnt != '0) sp_pend_next = 1'b1;
            end else begin
              if (sp_pend) broken_next = 1'b1;
              if (cnt == '0) first_next = rdata;
              match_next = match & step_ok;
              if (cnt != 4'hF) cnt_next = cnt + 1'b1;
            end
          end
        end
        S_FLUSH: begin
          have_pend_next = 1'b0;
          state_next     = S_IDLE;
        end
        default: state_next = S_IDLE;
      endcase
      if (adv_v) begin
        p_next     = adv_to;
        ptr_next   = adv_to;
        state_next = (adv_to >= n) ? S_FLUSH : S_CHAR;
      end
    end
  end

  // a one-character line reads the entry written at the same edge
  always_ff @(posedge clk) begin
    if (wr_en) mem[len] <= in_item.char_code;
    rdata <= (wr_en && ptr_next[AW-1:0] == len) ? in_item.char_code
                                                : mem[ptr_next[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      zs        <= 1'b0;
      have_pend <= 1'b0;
    end else begin
      state     <= state_next;
      len       <= len_next;
      zs        <= zs_next;
      have_pend <= have_pend_next;
    end
    zn       <= zn_next;
    n        <= n_next;
    p        <= p_next;
    q        <= q_next;
    ptr      <= ptr_next;
    in_piece <= in_piece_next;
    sp_pend  <= sp_pend_next;
    broken   <= broken_next;
    have_key <= have_key_next;
    cnt      <= cnt_next;
    first    <= first_next;
    all_mods <= all_mods_next;
    key      <= key_next;
    match    <= match_next;
    pend     <= pend_next;
  end

endmodule
`default_nettype wire

// ----- rtl/core/tthk_fifo.sv -----
// short result queue between the walker and the result port
// depends on tthk_pkg and the assertion macro header
`default_nettype none
`include "text_to_hid_key_combo_encoder_assert.svh"
module tthk_fifo import tthk_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    wr_en,
  input  wire result_t wr_data,
  output logic         q_full,
  output logic         empty,
  input  wire logic    pop,
  output result_t      rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  result_t       slots [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [CW-1:0] count;
  logic          rd_en;

  assign empty   = (count == '0);
  assign q_full  = (count == CW'(DEPTH));
  assign rd_en   = pop && !empty;
  assign rd_data = slots[rp];

  always_ff @(posedge clk) begin
    if (wr_en) slots[wp] <= wr_data;
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr_en) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (rd_en) rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      count <= count + CW'(wr_en) - CW'(rd_en);
    end
  end

  `TTHK_ASSERT(a_no_overflow, clk, rst, !(wr_en && q_full), "write into full result queue")
  `TTHK_ASSERT(a_count_up, clk, rst, (wr_en && !rd_en) |=> count == $past(count) + 1'b1, "count lost a write")
  `TTHK_ASSERT_RST(a_reset_empty, clk, rst |=> empty, "queue not empty after reset")

endmodule
`default_nettype wire

// ----- rtl/core/text_to_hid_key_combo_encoder.sv -----
// top level of the text line to hid key combo encoder
// depends on tthk_pkg, tthk_walk and tthk_fifo
`default_nettype none
// Characters are pushed into a line store one per cycle while full is low; a
// request with end_of_line set closes the line, and the walker then parses it
// from the store, producing key combos and error reports into a four-entry
// result queue. full stays high while a line is being walked. The walk goes
// through the line character by character; a backslash followed by another
// character takes an extra step to look at that character, a tag takes one
// pass to find the closing '>' and one to decode the pieces, a tag of bad
// length is scanned once, and an unclosed '<' scans to the end of the line
// before it is typed. The last result is held back until a final flush step
// to mark it as the last of the line. The line store has a single read port,
// and a full result queue stalls the walk.
module text_to_hid_key_combo_encoder import tthk_pkg::*; #(
  parameter int LINE_CHARS = 64,
  parameter int TAG_CHARS  = 64
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_item,
  output logic          empty,
  input  wire logic     pop,
  output result_t       out_item
);

  logic    q_full, q_wr;
  result_t q_data;

  tthk_walk #(
    .LINE_CHARS(LINE_CHARS),
    .TAG_CHARS (TAG_CHARS)
  ) u_walk (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .in_item(in_item),
    .q_full (q_full),
    .q_wr   (q_wr),
    .q_data (q_data)
  );

  tthk_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (q_wr),
    .wr_data(q_data),
    .q_full (q_full),
    .empty  (empty),
    .pop    (pop),
    .rd_data(out_item)
  );

endmodule
`default_nettype wire

// ----- dv/text_to_hid_key_combo_encoder_tb.sv -----
// testbench for the text line to hid key combo encoder
// depends on tthk_pkg and text_to_hid_key_combo_encoder; checks results against a line parser
`timescale 1ns / 100ps
`default_nettype none
module text_to_hid_key_combo_encoder_tb;
  import tthk_pkg::*;

  localparam int LINE_MAX = 64;
  localparam int TAG_MAX = 64;
  localparam int CYCLE_LIMIT = 1500000;

  class combo_scoreboard;
    byte unsigned line_buf[64];
    int line_len;
    result_t pending[$];
    int n_fail;
    int n_checked;
    int n_lines;

    function new();
      line_len = 0;
      n_fail = 0;
      n_checked = 0;
      n_lines = 0;
    endfunction

    function automatic bit ascii_usage(byte unsigned c, output logic [7:0] code,
                                       output logic [7:0] mods);
      mods = 8'h00;
      code = 8'h00;
      if (c >= "a" && c <= "z") begin
        code = 8'h04 + (c - "a");
        return 1;
      end
      if (c >= "A" && c <= "Z") begin
        code = 8'h04 + (c - "A");
        mods = MOD_SHIFT;
        return 1;
      end
      if (c == "0") begin
        code = 8'h27;
        return 1;
      end
      if (c >= "1" && c <= "9") begin
        code = 8'h1E + (c - "1");
        return 1;
      end
      case (c)
        8'h20: code = 8'h2C;
        8'h2E: code = 8'h37;
        8'h2C: code = 8'h36;
        8'h2D: code = 8'h2D;
        8'h3D: code = 8'h2E;
        8'h2F: code = 8'h38;
        8'h3B: code = 8'h33;
        8'h27: code = 8'h34;
        8'h5B: code = 8'h2F;
        8'h5D: code = 8'h30;
        8'h5C: code = 8'h31;
        8'h60: code = 8'h35;
        8'h09: code = 8'h2B;
        8'h0A: code = 8'h28;
        8'h3C: begin
          code = 8'h36;
          mods = MOD_SHIFT;
        end
        default: return 0;
      endcase
      return 1;
    endfunction

    function automatic void add_combo(logic [7:0] m, logic [7:0] k, ref int cnt);
      result_t r;
      if (cnt >= 63) return;
      r = '{result_kind: KIND_COMBO, modifier_bits: m, key_code: k,
            error_code: ERR_UNKNOWN, last_of_line: 1'b0};
      pending.push_back(r);
      cnt++;
    endfunction

    function automatic void add_error(logic [1:0] e, ref int cnt);
      result_t r;
      if (cnt >= 63) return;
      r = '{result_kind: KIND_ERROR, modifier_bits: 8'h00, key_code: 8'h00,
            error_code: e, last_of_line: 1'b0};
      pending.push_back(r);
      cnt++;
    endfunction

    function automatic byte unsigned lower(byte unsigned c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic bit lookup_name(int lo, int hi, output logic [7:0] code,
                                       output logic [7:0] mods);
      string names[40] = '{"ctrl", "control", "alt", "shift", "super", "win", "gui",
        "cmd", "enter", "return", "tab", "esc", "escape", "backspace", "delete", "del",
        "space", "up", "down", "left", "right", "home", "end", "pageup", "pagedown",
        "insert", "capslock", "printscreen", "f1", "f2", "f3", "f4", "f5", "f6", "f7",
        "f8", "f9", "f10", "f11", "f12"};
      byte unsigned codes[40] = '{0, 0, 0, 0, 0, 0, 0, 0, 8'h28, 8'h28, 8'h2B, 8'h29,
        8'h29, 8'h2A, 8'h4C, 8'h4C, 8'h2C, 8'h52, 8'h51, 8'h50, 8'h4F, 8'h4A, 8'h4D,
        8'h4B, 8'h4E, 8'h49, 8'h39, 8'h46, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F,
        8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45};
      byte unsigned modset[8] = '{MOD_CTRL, MOD_CTRL, MOD_ALT, MOD_SHIFT, MOD_GUI,
        MOD_GUI, MOD_GUI, MOD_GUI};
      int n;
      bit hit;
      n = hi - lo;
      for (int k = 0; k < 40; k++) begin
        if (names[k].len() == n) begin
          hit = 1;
          for (int j = 0; j < n; j++)
            if (lower(line_buf[lo + j]) != names[k][j]) hit = 0;
          if (hit) begin
            code = codes[k];
            mods = (k < 8) ? modset[k] : 8'h00;
            return 1;
          end
        end
      end
      if (n == 1) return ascii_usage(line_buf[lo], code, mods);
      code = 0;
      mods = 0;
      return 0;
    endfunction

    function automatic void decode_tag(int lo, int hi, ref int cnt);
      int i, ts, te;
      logic [7:0] all_mods, key, code, mods;
      bit have_key;
      i = lo;
      all_mods = 0;
      key = 0;
      have_key = 0;
      while (i < hi) begin
        while (i < hi && line_buf[i] == CH_PLUS) i++;
        if (i >= hi) break;
        ts = i;
        while (i < hi && line_buf[i] != CH_PLUS) i++;
        te = i;
        while (ts < te && line_buf[ts] == CH_SPACE) ts++;
        while (te - ts > 1 && line_buf[te - 1] == CH_SPACE) te--;
        if (!lookup_name(ts, te, code, mods)) begin
          add_error(ERR_UNKNOWN, cnt);
          return;
        end
        if (code == 0 && mods != 0) all_mods |= mods;
        else begin
          if (have_key) begin
            add_error(ERR_MULTI, cnt);
            return;
          end
          all_mods |= mods;
          key = code;
          have_key = 1;
        end
      end
      add_combo(all_mods, key, cnt);
    endfunction

    function automatic void note_request(in_item_t it);
      int n, p, q, cnt, first;
      logic [7:0] code, mods;
      if (line_len < LINE_MAX - 1) begin
        line_buf[line_len] = it.char_code;
        line_len++;
      end
      if (!it.end_of_line) return;
      n_lines++;
      n = 0;
      while (n < line_len && line_buf[n] != 0) n++;
      first = pending.size();
      cnt = 0;
      p = 0;
      while (p < n) begin
        if (line_buf[p] == CH_BSL && p + 1 < n && line_buf[p + 1] == CH_LT) begin
          add_combo(MOD_SHIFT, KEY_COMMA, cnt);
          p += 2;
        end else if (line_buf[p] == CH_LT) begin
          q = p + 1;
          while (q < n && line_buf[q] != CH_GT) q++;
          if (q >= n) begin
            add_combo(MOD_SHIFT, KEY_COMMA, cnt);
            p++;
          end else begin
            if (q - p - 1 == 0 || q - p - 1 >= TAG_MAX) add_error(ERR_LEN, cnt);
            else decode_tag(p + 1, q, cnt);
            p = q + 1;
          end
        end else begin
          if (ascii_usage(line_buf[p], code, mods)) add_combo(mods, code, cnt);
          p++;
        end
      end
      line_len = 0;
      if (pending.size() > first) pending[pending.size() - 1].last_of_line = 1'b1;
    endfunction

    function automatic void check_result(result_t got);
      result_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        n_fail++;
        return;
      end
      exp = pending.pop_front();
      n_checked++;
      if (got.result_kind !== exp.result_kind) begin
        $error("result_kind exp %h got %h", exp.result_kind, got.result_kind);
        n_fail++;
      end
      if (got.modifier_bits !== exp.modifier_bits) begin
        $error("modifier_bits exp %h got %h", exp.modifier_bits, got.modifier_bits);
        n_fail++;
      end
      if (got.key_code !== exp.key_code) begin
        $error("key_code exp %h got %h", exp.key_code, got.key_code);
        n_fail++;
      end
      if (got.error_code !== exp.error_code) begin
        $error("error_code exp %h got %h", exp.error_code, got.error_code);
        n_fail++;
      end
      if (got.last_of_line !== exp.last_of_line) begin
        $error("last_of_line exp %h got %h", exp.last_of_line, got.last_of_line);
        n_fail++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic pop = 0;
  logic full, empty;
  in_item_t in_item = '0;
  result_t out_item;
  int cycles = 0;
  int burst_left = 0;
  int n_sent = 0;
  combo_scoreboard sb;
  string tag_pool[12] = '{"ctrl+c", "CTRL + Alt+Del", "shift", "win+r", "++", " ",
    "enter", "ctrl+a+b", "foo", "F12", "Shift+<", "gui+space"};

  text_to_hid_key_combo_encoder u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && pop && !empty) sb.check_result(out_item);
    if (cycles > CYCLE_LIMIT) begin
      $display("text_to_hid_key_combo_encoder: mismatch");
      $finish;
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (rst) pop <= 0;
    else if (cycles % 600 < 150) pop <= 1;
    else pop <= (($urandom_range(0, 3) != 0) && (cycles % 7 != 3));
  end

  // push stays high between requests of one burst
  task automatic send_char(byte unsigned c, bit eol);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push <= 0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_item <= '{char_code: c, end_of_line: eol};
    push <= 1;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_request('{char_code: c, end_of_line: eol});
    n_sent++;
    @(negedge clk);
  endtask

  task automatic send_line(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  function automatic byte unsigned rand_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 8'($urandom_range(8'h61, 8'h7A));
    if (r == 4) return 8'($urandom_range(8'h41, 8'h5A));
    if (r == 5) return 8'($urandom_range(8'h20, 8'h7E));
    if (r == 6) return 8'($urandom_range(1, 255));
    if (r == 7) return CH_PLUS;
    return $urandom_range(0, 2) == 0 ? CH_BSL : CH_LT;
  endfunction

  task automatic send_random_line();
    string s;
    int len, k;
    s = "";
    len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      k = $urandom_range(0, 5);
      if (k < 2) s = {s, "<", tag_pool[$urandom_range(0, 11)], ">"};
      else if (k == 2) s = {s, "\\<"};
      else s = {s, string'(rand_char())};
    end
    if ($urandom_range(0, 9) == 0) begin
      for (int i = 0; i < s.len(); i++) send_char(s[i], 0);
      send_char(8'h00, 0);
      send_char(8'h61, 0);
      send_char(8'h62, 1);
    end else begin
      send_line(s);
    end
  endtask

  initial begin
    string longtag;
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed lines
    send_line("aZ09 .,-=/;'[]\\`<");
    send_line("<ctrl+alt+delete><>< ><++>");
    send_line("<a+b><foo><Shift+A>\\<x<up+");
    send_char(8'h09, 0);
    send_char(8'h0A, 0);
    send_char(8'hFF, 0);
    send_char(8'h80, 0);
    send_char(8'h00, 0);
    send_char(8'h41, 1);
    send_char(8'h62, 1);
    longtag = "<";
    for (int i = 0; i < 61; i++) longtag = {longtag, "a"};
    send_line({longtag, ">"});
    longtag = "";
    for (int i = 0; i < 70; i++) longtag = {longtag, "Q"};
    send_line(longtag);
    send_char(8'h61, 0);
    send_char(8'h7F, 0);
    send_char(8'h01, 1);
    // random lines
    while (n_sent < 360) send_random_line();
    push <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d lines, %0d results checked", sb.n_lines, sb.n_checked);
    if (sb.n_fail == 0) $display("text_to_hid_key_combo_encoder: match");
    else $display("text_to_hid_key_combo_encoder: mismatch");
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+rtl/core
rtl/core/tthk_pkg.sv
rtl/core/tthk_walk.sv
rtl/core/tthk_fifo.sv
rtl/core/text_to_hid_key_combo_encoder.sv
dv/text_to_hid_key_combo_encoder_tb.sv
